// ===== sv/vwss_pkg.sv =====
`timescale 1ns / 1ps

package vwss_pkg;

    localparam int MAX_RECORDS_DEF = 16;

    localparam int CFG_W     = 5;
    localparam int VOTES_W   = 64;
    localparam int KEY_LOW_W = 64;
    localparam int KEY_MID_W = 64;
    localparam int KEY_TOP_W = 32;
    localparam int SLOT_W    = 4;
    localparam int REC_W     = VOTES_W + KEY_LOW_W + KEY_MID_W + KEY_TOP_W;

    localparam logic [CFG_W-1:0] RECORD_COUNT_RST = CFG_W'(2);

    // Dividend of the home-slot division.
    localparam logic [VOTES_W-1:0] SHUFFLE_SEED = 64'd987654321123456823;
    localparam int DIV_BIT_W = $clog2(VOTES_W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_PROBE,
        ST_EMIT_RD,
        ST_EMIT_LD
    } t_state;

    typedef struct packed {
        logic start;
        logic div_step;
        logic probe;
        logic emit_load;
    } t_cmd;

    typedef struct packed {
        logic div_last;
        logic slot_free;
        logic batch_full;
        logic emit_last;
        logic out_free;
    } t_status;

endpackage

// ===== sv/vwss_ram.sv =====
`timescale 1ns / 1ps

module vwss_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/vwss_dp.sv =====
`timescale 1ns / 1ps

module vwss_dp #(
    parameter int MAX_RECORDS = vwss_pkg::MAX_RECORDS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_record_count_we,
    input  logic [vwss_pkg::CFG_W-1:0]          i_record_count,
    input  logic [vwss_pkg::VOTES_W-1:0]        i_votes,
    input  logic [vwss_pkg::KEY_LOW_W-1:0]      i_key_low,
    input  logic [vwss_pkg::KEY_MID_W-1:0]      i_key_mid,
    input  logic [vwss_pkg::KEY_TOP_W-1:0]      i_key_top,
    input  logic                                i_out_stall,
    input  vwss_pkg::t_cmd                      i_cmd,
    output vwss_pkg::t_status                   o_status,
    output logic                                o_out_valid,
    output logic [vwss_pkg::SLOT_W-1:0]         o_slot,
    output logic [vwss_pkg::VOTES_W-1:0]        o_out_votes,
    output logic [vwss_pkg::KEY_LOW_W-1:0]      o_out_key_low,
    output logic [vwss_pkg::KEY_MID_W-1:0]      o_out_key_mid,
    output logic [vwss_pkg::KEY_TOP_W-1:0]      o_out_key_top,
    output logic                                o_last_slot
);

    localparam int IDX_W  = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int CNT_W  = IDX_W + 1;
    localparam int NW     = (CNT_W > vwss_pkg::CFG_W) ? CNT_W : vwss_pkg::CFG_W;
    localparam int MOD_W  = IDX_W + 2;
    localparam int SEXT_W = IDX_W + vwss_pkg::SLOT_W;
    localparam int VW     = vwss_pkg::VOTES_W;
    localparam int LW     = vwss_pkg::KEY_LOW_W;
    localparam int MW     = vwss_pkg::KEY_MID_W;
    localparam int TW     = vwss_pkg::KEY_TOP_W;
    localparam int RW     = vwss_pkg::REC_W;

    logic [vwss_pkg::CFG_W-1:0]     r_rc;
    logic [VW-1:0]                  r_votes;
    logic [LW-1:0]                  r_key_low;
    logic [MW-1:0]                  r_key_mid;
    logic [TW-1:0]                  r_key_top;
    logic [VW-1:0]                  r_div;
    logic [VW-1:0]                  r_rem;
    logic [vwss_pkg::DIV_BIT_W-1:0] r_bit;
    logic [IDX_W-1:0]               r_pos;
    logic [MAX_RECORDS-1:0]         r_taken;
    logic [CNT_W-1:0]               r_loaded;
    logic [IDX_W-1:0]               r_emit;
    logic                           r_out_valid;
    logic [vwss_pkg::SLOT_W-1:0]    r_slot;
    logic [VW-1:0]                  r_out_votes;
    logic [LW-1:0]                  r_out_key_low;
    logic [MW-1:0]                  r_out_key_mid;
    logic [TW-1:0]                  r_out_key_top;
    logic                           r_last_slot;

    logic [NW-1:0]     rc_ext;
    logic [NW-1:0]     n_wide;
    logic [CNT_W-1:0]  n_eff;
    logic [VW:0]       shifted;
    logic              qbit;
    logic [VW:0]       rem_diff;
    logic [MOD_W-1:0]  mod_t;
    logic [MOD_W-1:0]  mod_n;
    logic [MOD_W-1:0]  mod_next;
    logic [CNT_W-1:0]  pos_inc;
    logic [CNT_W-1:0]  emit_inc;
    logic [SEXT_W-1:0] slot_ext;
    logic              slot_free;
    logic              ram_we;
    logic [RW-1:0]     ram_wdata;
    logic [RW-1:0]     ram_rdata;

    // Effective record count, clamped to one up to the table depth.
    always_comb begin
        rc_ext = NW'(r_rc);
        if (rc_ext == '0) begin
            n_wide = NW'(1);
        end else if (rc_ext > NW'(MAX_RECORDS)) begin
            n_wide = NW'(MAX_RECORDS);
        end else begin
            n_wide = rc_ext;
        end
        n_eff = n_wide[CNT_W-1:0];
    end

    // Restoring division of the seed by the votes, one quotient bit per cycle. The
    // quotient modulo n is folded in as each bit appears, most significant first.
    always_comb begin
        shifted  = {r_rem, vwss_pkg::SHUFFLE_SEED[r_bit]};
        rem_diff = shifted - {1'b0, r_div};
        qbit     = (shifted >= {1'b0, r_div});
        mod_t    = {1'b0, r_pos, qbit};
        mod_n    = MOD_W'(n_eff);
        mod_next = (mod_t >= mod_n) ? (mod_t - mod_n) : mod_t;
    end

    assign pos_inc   = CNT_W'(r_pos) + CNT_W'(1);
    assign emit_inc  = CNT_W'(r_emit) + CNT_W'(1);
    assign slot_ext  = SEXT_W'(r_emit);
    assign slot_free = !r_taken[r_pos];
    assign ram_we    = i_cmd.probe && slot_free;
    assign ram_wdata = {r_key_top, r_key_mid, r_key_low, r_votes};

    always_comb begin
        o_status.div_last   = (r_bit == '0);
        o_status.slot_free  = slot_free;
        o_status.batch_full = ((r_loaded + CNT_W'(1)) == n_eff);
        o_status.emit_last  = (emit_inc == n_eff);
        o_status.out_free   = !r_out_valid || !i_out_stall;
    end

    vwss_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_RECORDS),
        .ADDR_W(IDX_W)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_pos),
        .i_wdata(ram_wdata),
        .i_raddr(r_emit),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rc        <= vwss_pkg::RECORD_COUNT_RST;
            r_taken     <= '0;
            r_loaded    <= '0;
            r_emit      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.emit_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (ram_we) begin
                r_taken[r_pos] <= 1'b1;
                r_loaded       <= r_loaded + CNT_W'(1);
            end

            if (i_cmd.emit_load) begin
                if (o_status.emit_last) begin
                    r_taken  <= '0;
                    r_loaded <= '0;
                    r_emit   <= '0;
                end else begin
                    r_emit <= emit_inc[IDX_W-1:0];
                end
            end

            // A new record count discards any partial batch.
            if (i_record_count_we) begin
                r_rc     <= i_record_count;
                r_taken  <= '0;
                r_loaded <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_votes   <= i_votes;
            r_key_low <= i_key_low;
            r_key_mid <= i_key_mid;
            r_key_top <= i_key_top;
            r_div     <= (i_votes == '0) ? VW'(1) : i_votes;
            r_rem     <= '0;
            r_bit     <= vwss_pkg::DIV_BIT_W'(VW - 1);
            r_pos     <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= qbit ? rem_diff[VW-1:0] : shifted[VW-1:0];
            r_pos <= mod_next[IDX_W-1:0];
            r_bit <= r_bit - vwss_pkg::DIV_BIT_W'(1);
        end else if (i_cmd.probe && !slot_free) begin
            r_pos <= (pos_inc == n_eff) ? '0 : pos_inc[IDX_W-1:0];
        end

        if (i_cmd.emit_load) begin
            r_slot        <= slot_ext[vwss_pkg::SLOT_W-1:0];
            r_out_votes   <= ram_rdata[VW-1:0];
            r_out_key_low <= ram_rdata[VW+LW-1:VW];
            r_out_key_mid <= ram_rdata[VW+LW+MW-1:VW+LW];
            r_out_key_top <= ram_rdata[RW-1:VW+LW+MW];
            r_last_slot   <= o_status.emit_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_slot        = r_slot;
    assign o_out_votes   = r_out_votes;
    assign o_out_key_low = r_out_key_low;
    assign o_out_key_mid = r_out_key_mid;
    assign o_out_key_top = r_out_key_top;
    assign o_last_slot   = r_last_slot;

endmodule

// ===== sv/vwss_ctrl.sv =====
`timescale 1ns / 1ps

module vwss_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  vwss_pkg::t_status i_status,
    output vwss_pkg::t_cmd    o_cmd,
    output logic              o_in_stall
);

    vwss_pkg::t_state r_state;
    vwss_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vwss_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            vwss_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = vwss_pkg::ST_DIVIDE;
                end
            end
            vwss_pkg::ST_DIVIDE: begin
                if (i_status.div_last) begin
                    n_state = vwss_pkg::ST_PROBE;
                end
            end
            vwss_pkg::ST_PROBE: begin
                if (i_status.slot_free) begin
                    n_state = i_status.batch_full ? vwss_pkg::ST_EMIT_RD : vwss_pkg::ST_IDLE;
                end
            end
            vwss_pkg::ST_EMIT_RD: begin
                n_state = vwss_pkg::ST_EMIT_LD;
            end
            vwss_pkg::ST_EMIT_LD: begin
                if (i_status.out_free) begin
                    n_state = i_status.emit_last ? vwss_pkg::ST_IDLE : vwss_pkg::ST_EMIT_RD;
                end
            end
            default: begin
                n_state = vwss_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd.start     = (r_state == vwss_pkg::ST_IDLE) && i_in_valid;
        o_cmd.div_step  = (r_state == vwss_pkg::ST_DIVIDE);
        o_cmd.probe     = (r_state == vwss_pkg::ST_PROBE);
        o_cmd.emit_load = (r_state == vwss_pkg::ST_EMIT_LD) && i_status.out_free;
        o_in_stall      = (r_state != vwss_pkg::ST_IDLE);
    end

endmodule

// ===== sv/vote_weighted_slot_shuffle_unit.sv =====
`timescale 1ns / 1ps

// Channel   Handshake                     Payload
// input     i_in_valid / o_in_stall       i_votes, i_key_low, i_key_mid, i_key_top
// output    o_out_valid / i_out_stall     o_slot, o_out_votes, o_out_key_low/mid/top,
//                                         o_last_slot
// config    i_record_count_we             i_record_count
//
// A word is latched, then the seed is divided by the votes bit-serially (the modulo by n is
// folded into the same loop), then slots are probed in turn from the home slot until a free
// one is found. The word completing a batch then emits n slots from the slot RAM, each read
// and then loaded into the output register; a stall on the output holds the emission.
// Reset is synchronous and active low; it clears the slot-taken bits and the counters
// and sets the record count to two. A stall on the output holds the emitted word.

module vote_weighted_slot_shuffle_unit #(
    parameter int MAX_RECORDS = vwss_pkg::MAX_RECORDS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_record_count_we,
    input  logic [vwss_pkg::CFG_W-1:0]     i_record_count,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [vwss_pkg::VOTES_W-1:0]   i_votes,
    input  logic [vwss_pkg::KEY_LOW_W-1:0] i_key_low,
    input  logic [vwss_pkg::KEY_MID_W-1:0] i_key_mid,
    input  logic [vwss_pkg::KEY_TOP_W-1:0] i_key_top,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [vwss_pkg::SLOT_W-1:0]    o_slot,
    output logic [vwss_pkg::VOTES_W-1:0]   o_out_votes,
    output logic [vwss_pkg::KEY_LOW_W-1:0] o_out_key_low,
    output logic [vwss_pkg::KEY_MID_W-1:0] o_out_key_mid,
    output logic [vwss_pkg::KEY_TOP_W-1:0] o_out_key_top,
    output logic                           o_last_slot
);

    vwss_pkg::t_cmd    cmd;
    vwss_pkg::t_status status;

    vwss_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_status  (status),
        .o_cmd     (cmd),
        .o_in_stall(o_in_stall)
    );

    vwss_dp #(
        .MAX_RECORDS(MAX_RECORDS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_record_count_we(i_record_count_we),
        .i_record_count   (i_record_count),
        .i_votes          (i_votes),
        .i_key_low        (i_key_low),
        .i_key_mid        (i_key_mid),
        .i_key_top        (i_key_top),
        .i_out_stall      (i_out_stall),
        .i_cmd            (cmd),
        .o_status         (status),
        .o_out_valid      (o_out_valid),
        .o_slot           (o_slot),
        .o_out_votes      (o_out_votes),
        .o_out_key_low    (o_out_key_low),
        .o_out_key_mid    (o_out_key_mid),
        .o_out_key_top    (o_out_key_top),
        .o_last_slot      (o_last_slot)
    );

endmodule

// ===== sv/vwss_chk.sv =====
`timescale 1ns / 1ps

module vwss_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_stall,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input logic [vwss_pkg::SLOT_W-1:0]    o_slot,
    input logic [vwss_pkg::VOTES_W-1:0]   o_out_votes,
    input logic [vwss_pkg::KEY_LOW_W-1:0] o_out_key_low,
    input logic [vwss_pkg::KEY_MID_W-1:0] o_out_key_mid,
    input logic [vwss_pkg::KEY_TOP_W-1:0] o_out_key_top,
    input logic                           o_last_slot
);

    // A stalled output word stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_slot) && $stable(o_out_votes)
            && $stable(o_out_key_low) && $stable(o_out_key_mid)
            && $stable(o_out_key_top) && $stable(o_last_slot))
        else $error("stalled output word changed");

    // Mid-batch emission keeps the input side closed.
    a_emit_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last_slot |-> o_in_stall)
        else $error("input open while a batch is still being emitted");

    // Once the final slot has gone, nothing more comes out until a new batch is built.
    a_last_ends_batch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last_slot && !i_out_stall |=> !o_out_valid)
        else $error("output word followed the last slot of a batch");

    // An accepted word moves the controller out of idle, so the input always closes after it.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted on consecutive cycles");

endmodule

bind vote_weighted_slot_shuffle_unit vwss_chk u_vwss_chk (.*);

// ===== test/tb_vote_weighted_slot_shuffle_unit.sv =====
`timescale 1ns / 1ps

module tb_vote_weighted_slot_shuffle_unit;

    localparam int MAX_REC     = vwss_pkg::MAX_RECORDS_DEF;
    localparam int CFG_SETTLE  = 120;
    localparam int HOLD_OFF    = 400;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_TAIL  = 200;

    typedef struct packed {
        logic [vwss_pkg::VOTES_W-1:0]   votes;
        logic [vwss_pkg::KEY_LOW_W-1:0] key_low;
        logic [vwss_pkg::KEY_MID_W-1:0] key_mid;
        logic [vwss_pkg::KEY_TOP_W-1:0] key_top;
    } t_record;

    typedef struct packed {
        logic [vwss_pkg::SLOT_W-1:0]    slot;
        logic [vwss_pkg::VOTES_W-1:0]   votes;
        logic [vwss_pkg::KEY_LOW_W-1:0] key_low;
        logic [vwss_pkg::KEY_MID_W-1:0] key_mid;
        logic [vwss_pkg::KEY_TOP_W-1:0] key_top;
        logic                           last;
    } t_slot_word;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_record_count_we;
    logic [vwss_pkg::CFG_W-1:0]     i_record_count;
    logic                           i_in_valid;
    logic                           o_in_stall;
    logic [vwss_pkg::VOTES_W-1:0]   i_votes;
    logic [vwss_pkg::KEY_LOW_W-1:0] i_key_low;
    logic [vwss_pkg::KEY_MID_W-1:0] i_key_mid;
    logic [vwss_pkg::KEY_TOP_W-1:0] i_key_top;
    logic                           o_out_valid;
    logic                           i_out_stall;
    logic [vwss_pkg::SLOT_W-1:0]    o_slot;
    logic [vwss_pkg::VOTES_W-1:0]   o_out_votes;
    logic [vwss_pkg::KEY_LOW_W-1:0] o_out_key_low;
    logic [vwss_pkg::KEY_MID_W-1:0] o_out_key_mid;
    logic [vwss_pkg::KEY_TOP_W-1:0] o_out_key_top;
    logic                           o_last_slot;

    vote_weighted_slot_shuffle_unit #(
        .MAX_RECORDS(MAX_REC)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_record_count_we (i_record_count_we),
        .i_record_count    (i_record_count),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_votes           (i_votes),
        .i_key_low         (i_key_low),
        .i_key_mid         (i_key_mid),
        .i_key_top         (i_key_top),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_slot            (o_slot),
        .o_out_votes       (o_out_votes),
        .o_out_key_low     (o_out_key_low),
        .o_out_key_mid     (o_out_key_mid),
        .o_out_key_top     (o_out_key_top),
        .o_last_slot       (o_last_slot)
    );

    wire in_fire  = i_in_valid && !o_in_stall;
    wire out_fire = o_out_valid && !i_out_stall;

    // Shadow copy of the block's register and slot table.
    logic [vwss_pkg::CFG_W-1:0]     shuf_count = vwss_pkg::RECORD_COUNT_RST;
    int                             shuf_loaded = 0;
    bit                             shuf_taken [MAX_REC];
    logic [vwss_pkg::VOTES_W-1:0]   shuf_votes [MAX_REC];
    logic [vwss_pkg::KEY_LOW_W-1:0] shuf_key_low [MAX_REC];
    logic [vwss_pkg::KEY_MID_W-1:0] shuf_key_mid [MAX_REC];
    logic [vwss_pkg::KEY_TOP_W-1:0] shuf_key_top [MAX_REC];

    t_slot_word                   pending_slots[$];
    logic [vwss_pkg::VOTES_W-1:0] prev_votes = vwss_pkg::SHUFFLE_SEED;
    bit                           quiet = 1'b0;
    int                           hold_off_cycles = 0;
    int                           errors = 0;
    int                           words_sent = 0;
    int                           slots_checked = 0;
    int                           batches_done = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int active_count();
        if (shuf_count == 0)
            return 1;
        if (int'(shuf_count) > MAX_REC)
            return MAX_REC;
        return int'(shuf_count);
    endfunction

    function automatic void clear_shuffle();
        shuf_loaded = 0;
        for (int i = 0; i < MAX_REC; i++)
            shuf_taken[i] = 1'b0;
    endfunction

    // Places one record in the shadow table; a completed batch queues every slot.
    function automatic void place_record(input t_record r);
        int                           n;
        int                           pos;
        bit                           placed;
        logic [vwss_pkg::VOTES_W-1:0] divisor;
        t_slot_word                   w;
        n = active_count();
        divisor = (r.votes == '0) ? vwss_pkg::VOTES_W'(1) : r.votes;
        pos = int'((vwss_pkg::SHUFFLE_SEED / divisor) % vwss_pkg::VOTES_W'(n));
        placed = 1'b0;
        for (int t = 0; t < n; t++) begin
            if (!placed && !shuf_taken[pos]) begin
                shuf_taken[pos] = 1'b1;
                shuf_votes[pos] = r.votes;
                shuf_key_low[pos] = r.key_low;
                shuf_key_mid[pos] = r.key_mid;
                shuf_key_top[pos] = r.key_top;
                placed = 1'b1;
            end
            if (!placed)
                pos = (pos + 1 == n) ? 0 : pos + 1;
        end
        shuf_loaded = (shuf_loaded + 1) & 31;
        if (shuf_loaded >= n) begin
            for (int i = 0; i < n; i++) begin
                w.slot = vwss_pkg::SLOT_W'(i);
                w.votes = shuf_votes[i];
                w.key_low = shuf_key_low[i];
                w.key_mid = shuf_key_mid[i];
                w.key_top = shuf_key_top[i];
                w.last = (i + 1 == n);
                pending_slots = {pending_slots, w};
            end
            batches_done++;
            clear_shuffle();
        end
    endfunction

    function automatic logic [vwss_pkg::VOTES_W-1:0] pick_votes();
        logic [vwss_pkg::VOTES_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = '0;
            1, 2: v = vwss_pkg::VOTES_W'($urandom_range(1, 1000));
            3, 4: v = vwss_pkg::SHUFFLE_SEED / vwss_pkg::VOTES_W'($urandom_range(1, 5000));
            5: v = {$urandom, $urandom};
            6: v = vwss_pkg::SHUFFLE_SEED + vwss_pkg::VOTES_W'($urandom_range(0, 2))
                   - vwss_pkg::VOTES_W'(1);
            7: v = vwss_pkg::VOTES_W'($urandom);
            default: v = prev_votes;    // same home slot as before, forces probing
        endcase
        prev_votes = v;
        return v;
    endfunction

    function automatic t_record random_record();
        t_record r;
        r.votes = pick_votes();
        r.key_low = {$urandom, $urandom};
        r.key_mid = {$urandom, $urandom};
        r.key_top = $urandom;
        return r;
    endfunction

    task automatic send_record(input t_record r);
        if (!quiet && $urandom_range(0, 99) < 9) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat ($urandom_range(0, 5)) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_votes <= r.votes;
        i_key_low <= r.key_low;
        i_key_mid <= r.key_mid;
        i_key_top <= r.key_top;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        place_record(r);
        words_sent++;
    endtask

    // The sender rests until every queued slot has come out, then lets the
    // block finish any record that did not complete a batch.
    task automatic drain_slots();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_slots.size() != 0)
            @(posedge i_clk);
        repeat (CFG_SETTLE) @(negedge i_clk);
    endtask

    task automatic write_record_count(input logic [vwss_pkg::CFG_W-1:0] value);
        drain_slots();
        @(negedge i_clk);
        i_record_count_we <= 1'b1;
        i_record_count <= value;
        @(negedge i_clk);
        i_record_count_we <= 1'b0;
        shuf_count = value;
        clear_shuffle();
    endtask

    task automatic test_reset_count();
        send_record('{votes: '0, key_low: '0, key_mid: '0, key_top: '0});
        send_record('{votes: '1, key_low: '1, key_mid: '1, key_top: '1});
    endtask

    task automatic test_count_zero();
        write_record_count(vwss_pkg::CFG_W'(0));
        send_record('{votes: 64'd1, key_low: {16{4'hA}}, key_mid: {16{4'h5}},
                      key_top: {8{4'hA}}});
        send_record('{votes: vwss_pkg::SHUFFLE_SEED + 64'd1, key_low: {16{4'h5}},
                      key_mid: {16{4'hA}}, key_top: {8{4'h5}}});
    endtask

    // Every record of a full batch shares one home slot, so the probe wraps.
    task automatic test_count_clamp_high();
        t_record r;
        write_record_count(vwss_pkg::CFG_W'(31));
        for (int i = 0; i < MAX_REC; i++) begin
            r = random_record();
            r.votes = vwss_pkg::SHUFFLE_SEED;
            send_record(r);
        end
    endtask

    task automatic test_midbatch_rewrite();
        write_record_count(vwss_pkg::CFG_W'(4));
        repeat (2) send_record(random_record());
        write_record_count(vwss_pkg::CFG_W'(3));
        repeat (3) send_record(random_record());
    endtask

    task automatic test_output_hold_off();
        write_record_count(vwss_pkg::CFG_W'(2));
        hold_off_cycles = HOLD_OFF;
        repeat (10) send_record(random_record());
    endtask

    task automatic test_random_batches();
        logic [vwss_pkg::CFG_W-1:0] plan [10];
        int                         words;
        plan = '{5'd2, 5'd1, 5'd3, 5'd5, 5'd16, 5'd4, 5'd0, 5'd8, 5'd19, 5'd2};
        plan[9] = vwss_pkg::CFG_W'($urandom_range(0, 31));
        for (int p = 0; p < 10; p++) begin
            write_record_count(plan[p]);
            quiet = (p == 3);
            words = (plan[p] >= 16) ? 32 : 18;
            for (int i = 0; i < words; i++) begin
                if (p == 5 && i == words / 2)
                    drain_slots();
                send_record(random_record());
            end
            quiet = 1'b0;
        end
    endtask

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_slot_word want;
        if (i_rst_n && out_fire) begin
            if (pending_slots.size() == 0) begin
                errors++;
                $display("%0t: unexpected output word, expected none, actual slot %0d",
                         $time, o_slot);
            end else begin
                want = pending_slots.pop_front();
                check_field("slot", 64'(want.slot), 64'(o_slot));
                check_field("votes", want.votes, o_out_votes);
                check_field("key_low", want.key_low, o_out_key_low);
                check_field("key_mid", want.key_mid, o_out_key_mid);
                check_field("key_top", 64'(want.key_top), 64'(o_out_key_top));
                check_field("last_slot", 64'(want.last), 64'(o_last_slot));
                slots_checked++;
            end
        end
    end

    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_cycles > 0) begin
                i_out_stall <= 1'b1;
                hold_off_cycles--;
            end else begin
                i_out_stall <= !quiet && ($urandom_range(0, 99) < 9);
            end
        end
    end

    initial begin : watchdog
        int quiet_run;
        quiet_run = 0;
        while (quiet_run < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || in_fire || out_fire || i_record_count_we)
                quiet_run = 0;
            else
                quiet_run++;
        end
        $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("simulation failed");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        i_record_count_we = 1'b0;
        i_record_count = '0;
        i_in_valid = 1'b0;
        i_votes = '0;
        i_key_low = '0;
        i_key_mid = '0;
        i_key_top = '0;
        clear_shuffle();
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_count();
        test_count_zero();
        test_count_clamp_high();
        test_midbatch_rewrite();
        test_output_hold_off();
        test_random_batches();

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_slots.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);

        $display("Sent %0d records and checked %0d slot words from %0d batches.",
                 words_sent, slots_checked, batches_done);
        $display("Covered clamped record counts, a mid-batch rewrite, wrapping probes, %0s",
                 "random stalls and a long output hold-off.");
        if (errors == 0 && pending_slots.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
